// ===== design/stbs_pkg.sv =====
// shared types and constants for the sorted table binary search unit
package stbs_pkg;

   // default table depth
   localparam int STBS_MAX_ENTRIES = 1024;

   // fixed field widths
   localparam int DATA_W  = 32;
   localparam int POS_W   = 10;
   localparam int PROBE_W = 4;

   // item kinds carried in req_tuser[0]
   localparam logic MODE_APPEND = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   // one search result
   typedef struct packed {
      logic               found;
      logic [POS_W-1:0]   position;
      logic [PROBE_W-1:0] probe_count;
   } result_type;

endpackage

// ===== design/stbs_ram.sv =====
// generic single write port, single read port ram with registered read
module stbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== design/stbs_ctrl.sv =====
// table fill count, append writes and the binary search probe sequencer
module stbs_ctrl import stbs_pkg::*; #(
   parameter int MAX_ENTRIES = STBS_MAX_ENTRIES,
   localparam int AW = $clog2(MAX_ENTRIES),
   localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   // incoming item
   input  logic              item_valid,
   output logic              item_ready,
   input  logic              item_mode,
   input  logic              item_restart,
   input  logic [DATA_W-1:0] item_value,
   // table ram
   output logic              ram_wr_en,
   output logic [AW-1:0]     ram_wr_addr,
   output logic [DATA_W-1:0] ram_wr_data,
   output logic              ram_rd_en,
   output logic [AW-1:0]     ram_rd_addr,
   input  logic [DATA_W-1:0] ram_rd_data,
   // finished result
   output logic              res_valid,
   input  logic              res_ready,
   output result_type        res_data
);

   localparam int PCW = $clog2(CW + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ADDR = 2'd1;
   localparam logic [1:0] ST_CMP  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     low_ff, low_in;
   logic [CW-1:0]     end_ff, end_in;
   logic [AW-1:0]     mid_ff, mid_in;
   logic [PCW-1:0]    probe_ff, probe_in;
   logic              found_ff, found_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [DATA_W-1:0] key_ff, key_in;

   logic          accept;
   logic          room;
   logic [CW:0]   mid_sum;
   logic [AW-1:0] mid_calc;

   assign accept     = item_valid && item_ready;
   assign item_ready = (state_ff == ST_IDLE);
   assign room       = (count_ff < CW'(MAX_ENTRIES));

   // midpoint rounded down over the inclusive range low .. end-1
   assign mid_sum  = {1'b0, low_ff} + {1'b0, end_ff} - (CW+1)'(1);
   assign mid_calc = mid_sum[AW:1];

   // append write port
   assign ram_wr_en   = accept && (item_mode == MODE_APPEND) && (item_restart || room);
   assign ram_wr_addr = item_restart ? '0 : count_ff[AW-1:0];
   assign ram_wr_data = item_value;

   // probe read port
   assign ram_rd_en   = (state_ff == ST_ADDR) && (low_ff < end_ff);
   assign ram_rd_addr = mid_calc;

   // result
   assign res_valid            = (state_ff == ST_FIN);
   assign res_data.found       = found_ff;
   assign res_data.position    = POS_W'(pos_ff);
   assign res_data.probe_count = PROBE_W'(probe_ff);

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      low_in   = low_ff;
      end_in   = end_ff;
      mid_in   = mid_ff;
      probe_in = probe_ff;
      found_in = found_ff;
      pos_in   = pos_ff;
      key_in   = key_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (item_mode == MODE_APPEND) begin
                  if (item_restart) begin
                     count_in = CW'(1);
                  end else if (room) begin
                     count_in = count_ff + CW'(1);
                  end
               end else begin
                  key_in   = item_value;
                  low_in   = '0;
                  end_in   = count_ff;
                  probe_in = '0;
                  found_in = 1'b0;
                  pos_in   = '0;
                  state_in = ST_ADDR;
               end
            end
         end
         ST_ADDR: begin
            if (low_ff < end_ff) begin
               mid_in   = mid_calc;
               state_in = ST_CMP;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_CMP: begin
            probe_in = probe_ff + PCW'(1);
            if (ram_rd_data == key_ff) begin
               found_in = 1'b1;
               pos_in   = mid_ff;
               state_in = ST_FIN;
            end else begin
               if ($signed(key_ff) < $signed(ram_rd_data)) begin
                  end_in = CW'(mid_ff);
               end else begin
                  low_in = CW'(mid_ff) + CW'(1);
               end
               state_in = ST_ADDR;
            end
         end
         ST_FIN: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // search registers
   always_ff @(posedge clock) begin
      low_ff   <= low_in;
      end_ff   <= end_in;
      mid_ff   <= mid_in;
      probe_ff <= probe_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
      key_ff   <= key_in;
   end

endmodule

// ===== design/sorted_table_binary_search_unit.sv =====
// top level of the sorted table binary search unit
//
//  channel | dir | tdata                              | tuser
//  req     | in  | [31:0] value (signed)              | [0] mode, [1] restart
//  rsp     | out | [9:0] position, [13:10] probe_count| [0] found
//
// an append gives no result; a search passes through an address state and a compare
// state for each probe and ends in a final state, on a hit straight from the compare
// and on a miss from the address state once the range is empty; each probe is a
// registered table ram read followed by a compare
// reset clears the fill count and control state; table contents are not cleared
// a stalled result sits in the output register; the search engine holds in its
// final state until that register frees up
module sorted_table_binary_search_unit import stbs_pkg::*; #(
   parameter int MAX_ENTRIES = STBS_MAX_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [0] mode, [1] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [9:0] position, [13:10] probe_count, [15:14] zero
   output logic [0:0]  rsp_tuser    // [0] found
);

   localparam int AW = $clog2(MAX_ENTRIES);

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;
   logic              res_valid;
   logic              res_ready;
   result_type        res_data;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   // sequencer
   stbs_ctrl #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (req_tvalid),
      .item_ready   (req_tready),
      .item_mode    (req_tuser[0]),
      .item_restart (req_tuser[1]),
      .item_value   (req_tdata),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res_data     (res_data)
   );

   // table storage
   stbs_ram #(
      .WIDTH(DATA_W),
      .DEPTH(MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // output register
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // result ports
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_data_ff.found;
   assign rsp_tdata    = {2'b00, rsp_data_ff.probe_count, rsp_data_ff.position};

endmodule

// ===== design/stbs_checker.sv =====
// port level checks for the sorted table binary search unit, bound to the top level
module stbs_checker import stbs_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // no result is shown right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // a miss reports position zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[9:0] == 10'd0)
      else $error("miss with nonzero position");

   // a search item keeps the input closed in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] == MODE_SEARCH |=> !req_tready)
      else $error("input open during search");

endmodule

bind sorted_table_binary_search_unit stbs_checker u_stbs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
